>>> design/oid_to_dotted_decimal_macros.svh
// ----------------------------------------------------------------------------
// OID to dotted decimal: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off in reset.
// ----------------------------------------------------------------------------
`ifndef OID_TO_DOTTED_DECIMAL_MACROS_SVH
`define OID_TO_DOTTED_DECIMAL_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define OIDD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OIDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/oidd_pkg.sv
// ----------------------------------------------------------------------------
// OID to dotted decimal: package
// Payload types, job format, state encodings and decimal helpers.
// ----------------------------------------------------------------------------
package oidd_pkg;

    localparam int MAX_TEXT_LEN_DEF = 128;
    localparam int TEXT_LEN_W       = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int DEC_DIGITS       = 10;
    localparam int DIG_IDX_W        = $clog2(DEC_DIGITS);
    localparam int DIG_CNT_W        = $clog2(DEC_DIGITS + 1);

    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_DOT  = 8'h2E;
    // floor(v / 10) == (v * RECIP_TEN) >> 35 for every 32-bit v
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [31:0] POW10 [DEC_DIGITS] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    typedef struct packed {
        logic [7:0] oid_byte;
        logic       end_of_object;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_char;
        logic       char_valid;
        logic       last_of_object;
        logic       status;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_MARK,
        JOB_FIRST,
        JOB_ARC
    } t_job_kind;

    // One unit of print work handed from the front to the back.
    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  hi;
        logic [31:0] lo;
        logic        last;
        logic        status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SPLIT,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL,
        BE_REM,
        BE_HI,
        BE_DOT,
        BE_DIG,
        BE_MARK
    } t_be_state;

    // Number of decimal digits of v (at least one).
    function automatic logic [DIG_CNT_W-1:0] dec_digit_count(input logic [31:0] v);
        logic [DIG_CNT_W-1:0] c;
        c = DIG_CNT_W'(1);
        for (int k = 1; k < DEC_DIGITS; k++) begin
            if (v >= POW10[k]) begin
                c = c + DIG_CNT_W'(1);
            end
        end
        return c;
    endfunction

endpackage

>>> design/oidd_queue.sv
// ----------------------------------------------------------------------------
// OID to dotted decimal: job queue
// Short first-in first-out buffer of print jobs between front and back.
// ----------------------------------------------------------------------------
module oidd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  oidd_pkg::t_job        i_push_job,
    input  logic                  i_pop,
    output oidd_pkg::t_job        o_pop_job,
    output oidd_pkg::t_queue_status o_status
);
    import oidd_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_pop_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

>>> design/oidd_front.sv
// ----------------------------------------------------------------------------
// OID to dotted decimal: front end
// Take BER content bytes, collect arcs, split the first value, queue jobs.
// ----------------------------------------------------------------------------
`include "oid_to_dotted_decimal_macros.svh"

module oidd_front #(
    parameter int MAX_TEXT_LEN = oidd_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  oidd_pkg::t_in_item      i_in_data,
    output logic                    o_push,
    output oidd_pkg::t_job          o_push_job,
    input  oidd_pkg::t_queue_status i_q_status
);
    import oidd_pkg::*;

    localparam logic [TEXT_LEN_W-1:0] LimitLen = TEXT_LEN_W'(MAX_TEXT_LEN);
    localparam logic [TEXT_LEN_W-1:0] LenBound = TEXT_LEN_W'(MAX_TEXT_LEN + 12);

    t_fe_state             r_fe_state, n_fe_state;
    logic [63:0]           r_acc, n_acc;
    logic                  r_pending, n_pending;
    logic                  r_first_done, n_first_done;
    logic [TEXT_LEN_W-1:0] r_text_len, n_text_len;
    t_job                  r_job, n_job;

    logic                  w_accept;
    logic                  w_small;
    logic [6:0]            w_small_lo;
    logic [DIG_CNT_W-1:0]  w_digits;
    logic [DIG_CNT_W-1:0]  w_chars;

    assign o_in_stall = (r_fe_state != FE_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push_job = r_job;

    // First value is below 80 only if every bit above the low seven is clear.
    assign w_small    = (r_acc[63:7] == '0) && (r_acc[6:0] < 7'd80);
    assign w_small_lo = (r_acc[6:0] >= 7'd40) ? (r_acc[6:0] - 7'd40) : r_acc[6:0];
    assign w_digits   = dec_digit_count(r_job.lo);
    assign w_chars    = w_digits + ((r_job.kind == JOB_FIRST) ? DIG_CNT_W'(2) : DIG_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe_state   <= FE_IDLE;
            r_acc        <= '0;
            r_pending    <= 1'b0;
            r_first_done <= 1'b0;
            r_text_len   <= '0;
        end else begin
            r_fe_state   <= n_fe_state;
            r_acc        <= n_acc;
            r_pending    <= n_pending;
            r_first_done <= n_first_done;
            r_text_len   <= n_text_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_comb begin
        n_fe_state   = r_fe_state;
        n_acc        = r_acc;
        n_pending    = r_pending;
        n_first_done = r_first_done;
        n_text_len   = r_text_len;
        n_job        = r_job;
        o_push       = 1'b0;
        unique case (r_fe_state)
            FE_IDLE: begin
                if (w_accept) begin
                    n_job.last   = i_in_data.end_of_object;
                    n_job.status = 1'b0;
                    if (r_text_len < LimitLen) begin
                        n_acc = {r_acc[56:0], i_in_data.oid_byte[6:0]};
                        if (i_in_data.oid_byte[7]) begin
                            n_pending = 1'b1;
                            if (i_in_data.end_of_object) begin
                                n_job.kind   = JOB_MARK;
                                n_job.status = 1'b1;
                                n_fe_state   = FE_PUSH;
                            end
                        end else begin
                            n_pending  = 1'b0;
                            n_fe_state = FE_SPLIT;
                        end
                    end else if (i_in_data.end_of_object) begin
                        n_job.kind   = JOB_MARK;
                        n_job.status = r_pending;
                        n_fe_state   = FE_PUSH;
                    end
                end
            end
            FE_SPLIT: begin
                // Closed arc: the first one splits into two arcs.
                if (!r_first_done) begin
                    n_job.kind = JOB_FIRST;
                    if (w_small) begin
                        n_job.hi = {1'b0, (r_acc[6:0] >= 7'd40)};
                        n_job.lo = {25'b0, w_small_lo};
                    end else begin
                        n_job.hi = 2'd2;
                        n_job.lo = r_acc[31:0] - 32'd80;
                    end
                end else begin
                    n_job.kind = JOB_ARC;
                    n_job.hi   = 2'd0;
                    n_job.lo   = r_acc[31:0];
                end
                n_acc        = '0;
                n_first_done = 1'b1;
                n_fe_state   = FE_PUSH;
            end
            FE_PUSH: begin
                if (!i_q_status.full) begin
                    o_push = 1'b1;
                    if (r_job.kind != JOB_MARK) begin
                        n_text_len = r_text_len + TEXT_LEN_W'(w_chars);
                    end
                    if (r_job.last) begin
                        n_acc        = '0;
                        n_pending    = 1'b0;
                        n_first_done = 1'b0;
                        n_text_len   = '0;
                    end
                    n_fe_state = FE_IDLE;
                end
            end
            default: begin
                n_fe_state = FE_IDLE;
            end
        endcase
    end

    `OIDD_ASSERT_IMPL(a_mark_is_last, (r_fe_state == FE_PUSH) && (r_job.kind == JOB_MARK), r_job.last, "end marker job without end of identifier")
    `OIDD_ASSERT(a_text_len_bound, r_text_len < LenBound, "text length past limit plus one arc")

endmodule

>>> design/oidd_back.sv
// ----------------------------------------------------------------------------
// OID to dotted decimal: back end
// Convert queued values to decimal and emit one character per transfer.
// ----------------------------------------------------------------------------
`include "oid_to_dotted_decimal_macros.svh"

module oidd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  oidd_pkg::t_job          i_pop_job,
    input  oidd_pkg::t_queue_status i_q_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output oidd_pkg::t_out_item     o_out_data
);
    import oidd_pkg::*;

    t_be_state            r_state, n_state;
    t_job                 r_job, n_job;
    logic [31:0]          r_val, n_val;
    logic [63:0]          r_prod, n_prod;
    logic [DIG_CNT_W-1:0] r_nd, n_nd;
    logic [DIG_IDX_W-1:0] r_idx, n_idx;
    logic [3:0]           r_digits [DEC_DIGITS];
    t_out_item            r_out, n_out;
    logic                 r_out_valid;

    logic                 w_free;
    logic                 w_load;
    logic                 w_dig_we;
    logic [28:0]          w_q;
    logic [31:0]          w_q10;
    logic [31:0]          w_rem;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Quotient from the registered reciprocal product, digit as the remainder.
    assign w_q   = r_prod[63:RECIP_SHIFT];
    assign w_q10 = {w_q, 3'b000} + {2'b00, w_q, 1'b0};
    assign w_rem = r_val - w_q10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_val  <= n_val;
        r_prod <= n_prod;
        r_nd   <= n_nd;
        r_idx  <= n_idx;
        if (w_load) begin
            r_out <= n_out;
        end
        if (w_dig_we) begin
            r_digits[r_nd[DIG_IDX_W-1:0]] <= w_rem[3:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_val    = r_val;
        n_prod   = r_prod;
        n_nd     = r_nd;
        n_idx    = r_idx;
        n_out    = r_out;
        o_pop    = 1'b0;
        w_load   = 1'b0;
        w_dig_we = 1'b0;
        unique case (r_state)
            BE_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_pop_job;
                    n_val   = i_pop_job.lo;
                    n_nd    = '0;
                    n_state = (i_pop_job.kind == JOB_MARK) ? BE_MARK : BE_MUL;
                end
            end
            BE_MUL: begin
                n_prod  = r_val * RECIP_TEN;
                n_state = BE_REM;
            end
            BE_REM: begin
                w_dig_we = 1'b1;
                n_nd     = r_nd + DIG_CNT_W'(1);
                n_idx    = r_nd[DIG_IDX_W-1:0];
                n_val    = {3'b000, w_q};
                if (w_q == '0) begin
                    n_state = (r_job.kind == JOB_FIRST) ? BE_HI : BE_DOT;
                end else begin
                    n_state = BE_MUL;
                end
            end
            BE_HI: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_out   = '{text_char: CHAR_ZERO + {6'b0, r_job.hi}, char_valid: 1'b1,
                                last_of_object: 1'b0, status: 1'b0};
                    n_state = BE_DOT;
                end
            end
            BE_DOT: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_out   = '{text_char: CHAR_DOT, char_valid: 1'b1,
                                last_of_object: 1'b0, status: 1'b0};
                    n_state = BE_DIG;
                end
            end
            BE_DIG: begin
                if (w_free) begin
                    w_load = 1'b1;
                    n_out  = '{text_char: CHAR_ZERO + {4'b0, r_digits[r_idx]}, char_valid: 1'b1,
                               last_of_object: (r_idx == '0) && r_job.last, status: 1'b0};
                    if (r_idx == '0) begin
                        n_state = BE_IDLE;
                    end else begin
                        n_idx = r_idx - DIG_IDX_W'(1);
                    end
                end
            end
            BE_MARK: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_out   = '{text_char: 8'h00, char_valid: 1'b0,
                                last_of_object: 1'b1, status: r_job.status};
                    n_state = BE_IDLE;
                end
            end
            default: begin
                n_state = BE_IDLE;
            end
        endcase
    end

    `OIDD_ASSERT_IMPL(a_idx_in_range, r_state == BE_DIG, DIG_CNT_W'(r_idx) < r_nd, "digit index beyond converted digits")
    `OIDD_ASSERT_IMPL(a_nd_bound, (r_state == BE_REM) || (r_state == BE_DIG), r_nd <= DIG_CNT_W'(DEC_DIGITS), "more decimal digits than a 32-bit value has")

endmodule

>>> design/oid_to_dotted_decimal.sv
// ----------------------------------------------------------------------------
// OID to dotted decimal: top level
// BER object identifier content bytes in, dotted decimal ASCII text out.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                   payload
//   --------  ---------  --------------------------  ------------------------
//   in        input      i_in_valid / o_in_stall     i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall   o_out_data (t_out_item)
//
// A continuation byte (bit 7 set) is taken and the next byte can follow at
// once. A closing byte stalls the input while the front end splits the value
// (FE_SPLIT) and queues a print job (FE_PUSH), longer only if the job queue
// is full.
// The back end converts a value with one shared reciprocal multiplier, a
// multiply step and a remainder step per decimal digit, then emits one
// character per cycle while the output is not stalled.
// Reset (synchronous, active low) empties the queue and output register and
// clears the arc state; an output stall holds the output register, and the
// front end keeps taking bytes until the two-entry queue fills.
//
module oid_to_dotted_decimal #(
    parameter int MAX_TEXT_LEN = oidd_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  oidd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output oidd_pkg::t_out_item o_out_data
);
    import oidd_pkg::*;

    // Job handoff between front and back end.
    logic          w_push;
    t_job          w_push_job;
    logic          w_pop;
    t_job          w_pop_job;
    t_queue_status w_q_status;

    // Front end: collect arcs, split the first value, enforce the text limit.
    oidd_front #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_push_job (w_push_job),
        .i_q_status (w_q_status)
    );

    // Decouple the two sides so each can stall on its own.
    oidd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_status   (w_q_status)
    );

    // Back end: decimal conversion and one character per output transfer.
    oidd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_job   (w_pop_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/sv/tb_oid_to_dotted_decimal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OID to dotted decimal: testbench
// Sends BER object identifier content bytes, predicts the dotted decimal text
// character by character and checks every output transfer against it, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_oid_to_dotted_decimal;
    import oidd_pkg::*;

    localparam int TEXT_LIMIT = MAX_TEXT_LEN_DEF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    oid_to_dotted_decimal dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Characters still owed by the block, oldest first.
    t_out_item expected_chars[$];

    // Own copy of the arc state, updated on every accepted input transfer.
    logic [63:0] oid_value_acc = '0;
    logic        oid_arc_open = 1'b0;
    logic        oid_split_done = 1'b0;
    logic [7:0]  oid_text_len = '0;
    int          chars_this_byte;

    bit failed = 1'b0;
    bit in_jitter = 1'b0;
    bit out_jitter = 1'b0;
    int items_sent = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void push_char(input logic [7:0] ch);
        t_out_item c;
        c.text_char      = ch;
        c.char_valid     = 1'b1;
        c.last_of_object = 1'b0;
        c.status         = 1'b0;
        expected_chars.push_back(c);
        chars_this_byte++;
    endfunction

    // Emit the decimal digits of v, most significant first.
    function automatic void push_decimal(input logic [31:0] v);
        logic [7:0] digs [0:9];
        int nd;
        nd = 0;
        do begin
            digs[nd] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
            nd++;
        end while (v != 0);
        while (nd > 0) begin
            nd--;
            push_char(digs[nd]);
        end
    endfunction

    function automatic void convert_oid_byte(input t_in_item item);
        logic [63:0] value;
        logic [31:0] lead;
        logic [31:0] tail;
        t_out_item   fin;
        chars_this_byte = 0;
        // Past the text limit the byte is dropped, but an end still closes the object.
        if (oid_text_len < TEXT_LIMIT) begin
            oid_value_acc = {oid_value_acc[56:0], item.oid_byte[6:0]};
            if (item.oid_byte[7]) begin
                oid_arc_open = 1'b1;
            end else begin
                value = oid_value_acc;
                oid_arc_open = 1'b0;
                if (!oid_split_done) begin
                    // First value carries two arcs; 80 and above all belong to arc 2.
                    if (value < 64'd80) begin
                        lead = 32'(value / 64'd40);
                        tail = 32'(value % 64'd40);
                    end else begin
                        lead = 32'd2;
                        tail = 32'(value - 64'd80);
                    end
                    push_decimal(lead);
                    push_char(CHAR_DOT);
                    push_decimal(tail);
                    oid_split_done = 1'b1;
                end else begin
                    push_char(CHAR_DOT);
                    push_decimal(value[31:0]);
                end
                oid_text_len = oid_text_len + 8'(chars_this_byte);
                oid_value_acc = '0;
            end
        end
        if (item.end_of_object) begin
            if (chars_this_byte > 0) begin
                fin = expected_chars.pop_back();
            end else begin
                fin.text_char  = 8'h00;
                fin.char_valid = 1'b0;
            end
            fin.last_of_object = 1'b1;
            fin.status         = oid_arc_open;
            expected_chars.push_back(fin);
            oid_value_acc  = '0;
            oid_arc_open   = 1'b0;
            oid_split_done = 1'b0;
            oid_text_len   = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transfer per call, predicted at the edge it is taken
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eoo);
        t_in_item item;
        item.oid_byte      = b;
        item.end_of_object = eoo;
        // Drop valid now and then.
        if (in_jitter && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        // Hold the payload until the block takes it.
        do @(posedge i_clk); while (o_in_stall);
        convert_oid_byte(item);
        items_sent++;
    endtask

    // Hold off the sender until every owed character has arrived.
    task automatic wait_for_text();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Favor the extremes of the 7-bit group payload.
    function automatic logic [6:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 7'h00;
        if (r < 20) return 7'h7F;
        return 7'($urandom_range(127));
    endfunction

    // Mostly short arcs, some near the 32-bit edge, a few past 64 bits.
    function automatic int pick_groups();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 1;
        if (r < 75) return 2;
        if (r < 90) return $urandom_range(3, 5);
        if (r < 97) return 5;
        return $urandom_range(6, 11);
    endfunction

    // One arc: continuation groups, then a closing group.
    task automatic send_arc(input int groups, input bit closes_object);
        for (int g = 0; g < groups; g++) begin
            send_byte({g < groups - 1, pick_payload()},
                      closes_object && (g == groups - 1));
        end
    endtask

    task automatic send_random_object();
        int arcs;
        int len;
        if ($urandom_range(99) < 80) begin
            arcs = $urandom_range(1, 6);
            for (int a = 0; a < arcs; a++) begin
                send_arc(pick_groups(), a == arcs - 1);
            end
        end else begin
            // Noise: raw bytes, so the end may land inside an open arc.
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(255)), k == len - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // 1.2.840.113549
        send_byte(8'h2A, 1'b0); send_byte(8'h86, 1'b0); send_byte(8'h48, 1'b0);
        send_byte(8'h86, 1'b0); send_byte(8'hF7, 1'b0); send_byte(8'h0D, 1'b1);
        // Split edges: 0.0, 1.39, 2.0
        send_byte(8'h00, 1'b1);
        send_byte(8'h4F, 1'b1);
        send_byte(8'h50, 1'b1);
        // Largest first value that prints: 2.4294967295, twelve characters
        send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h4F, 1'b1);
        // End on a continuation byte: bare marker flagged incomplete
        send_byte(8'hFF, 1'b1);
        // 1.3.4294967295, largest later arc
        send_byte(8'h2B, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_random_objects(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            send_random_object();
            if ($urandom_range(99) < 4) wait_for_text();
        end
    endtask

    // Back-to-back transfers on both sides, with no random gaps or stalls.
    task automatic test_no_gaps(input int count);
        in_jitter  = 1'b0;
        out_jitter = 1'b0;
        test_random_objects(count);
        wait_for_text();
        in_jitter  = 1'b1;
        out_jitter = 1'b1;
    endtask

    // Run the text past the length limit, then feed bytes that must be dropped.
    task automatic test_text_limit(input int objects);
        for (int o = 0; o < objects; o++) begin
            send_arc($urandom_range(1, 2), 1'b0);
            while (oid_text_len < TEXT_LIMIT) begin
                send_arc($urandom_range(3, 5), 1'b0);
            end
            repeat ($urandom_range(2, 8)) send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and per-transfer check
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected output transfer, expected none, actual %0h",
                         $time, o_out_data);
                failed = 1'b1;
            end else begin
                want = expected_chars.pop_front();
                check_field("text_char", want.text_char, o_out_data.text_char);
                check_field("char_valid", want.char_valid, o_out_data.char_valid);
                check_field("last_of_object", want.last_of_object,
                            o_out_data.last_of_object);
                check_field("status", want.status, o_out_data.status);
            end
        end
        i_out_stall <= out_jitter && ($urandom_range(99) < 12);
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_jitter  = 1'b1;
        out_jitter = 1'b1;

        test_directed();
        wait_for_text();
        test_random_objects(200);
        wait_for_text();
        test_no_gaps(100);
        test_text_limit(2);
        test_random_objects(60);
        wait_for_text();

        // Give a trailing stray transfer time to show up.
        repeat (60) @(posedge i_clk);
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/oidd_pkg.sv
design/oidd_queue.sv
design/oidd_front.sv
design/oidd_back.sv
design/oid_to_dotted_decimal.sv
tb/sv/tb_oid_to_dotted_decimal.sv
